[src/simpson_quartic_integrator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Simpson quartic integrator.
// The full forms are used in simulation; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef SIMPSON_QUARTIC_INTEGRATOR_MACROS_SVH
`define SIMPSON_QUARTIC_INTEGRATOR_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define SQI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must never be true out of reset.
`define SQI_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SQI_ASSERT(label, prop, msg)
`define SQI_NEVER(label, cond, msg)
`endif

`endif

[src/sqi_pkg.sv]
// ----------------------------------------------------------------------------
// sqi_pkg
// Constants and the saturating adder used by the Simpson quartic integrator.
// ----------------------------------------------------------------------------
package sqi_pkg;

  localparam int unsigned MAX_PAIRS = 65536;
  localparam int unsigned PAIR_W    = 17;
  localparam int unsigned N_W       = 18;
  localparam int unsigned DIVR_W    = 35;
  localparam int unsigned IN_W      = 88;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // Returns {saturated, sum} of a signed 64-bit add.
  function automatic logic [64:0] sat_add(logic [63:0] x, logic [63:0] y);
    logic [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      return {1'b1, (s[64] ? S64_MIN : S64_MAX)};
    end
    return {1'b0, s[63:0]};
  endfunction

endpackage

[src/simpson_quartic_integrator.sv]
// ----------------------------------------------------------------------------
// simpson_quartic_integrator
// Composite Simpson integral of x^4 + 4x, fixed point, one shared multiplier,
// one shared saturating adder and one restoring divider under a sequencer.
// ----------------------------------------------------------------------------
// Words are taken one at a time: the next word is taken once the previous
// result is in the output register. Each sample makes four passes through the
// shared 32x32 multiplier.
// Reset (rst_n low at a clock edge) returns to idle and empties the output.
// ----------------------------------------------------------------------------
`include "simpson_quartic_integrator_macros.svh"

module simpson_quartic_integrator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // in_tdata, lowest bit up: lower_bound[31:0], upper_bound[63:32],
  // pair_count[80:64], zero fill [87:81].
  input  logic [sqi_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // out_tdata: integral[63:0].
  output logic [63:0]               out_tdata,
  // out_tuser: overflow[0].
  output logic                      out_tuser
);
  import sqi_pkg::*;

  // The sequencer walks a setup division, the sample loop, the two end
  // points, the weighted combine, the final multiply and the final division.
  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_DIV  = 17'h00002,
    ST_DEND = 17'h00004,
    ST_ADV  = 17'h00008,
    ST_XS   = 17'h00010,
    ST_SQ   = 17'h00020,
    ST_ML   = 17'h00040,
    ST_MM   = 17'h00080,
    ST_MH   = 17'h00100,
    ST_MF   = 17'h00200,
    ST_PF   = 17'h00400,
    ST_ACC  = 17'h00800,
    ST_COMB = 17'h01000,
    ST_MUL0 = 17'h02000,
    ST_MUL1 = 17'h04000,
    ST_MUL2 = 17'h08000,
    ST_FIN  = 17'h10000
  } state_t;

  // Which point the polynomial pass is evaluating.
  typedef enum logic [1:0] {
    SRC_SAMPLE = 2'd0,
    SRC_A      = 2'd1,
    SRC_B      = 2'd2
  } src_t;

  state_t            state_r;
  src_t              src_r;
  logic [31:0]       a_r, b_r;
  logic [N_W-1:0]    n_r;
  logic              d_neg_r;
  logic [31:0]       dm_r;
  logic [31:0]       q_r, qs_r;
  logic [N_W-1:0]    r_r, rs_r, i_r;
  logic [31:0]       x_r;
  logic [63:0]       prod_r, sq_r;
  logic [127:0]      acc_r;
  logic [63:0]       f_r, k1_r, k2_r, fa_r, fb_r, t_r, s_r;
  logic              ov_r;
  logic [2:0]        cstep_r;
  logic [6:0]        cnt_r;
  logic              phase_r;
  logic [DIVR_W-1:0] rem_r, dvsr_r;
  logic              out_tvalid_r;
  logic [63:0]       out_data_r;
  logic              out_ov_r;

  // Input decode: pair count is forced into 1..MAX_PAIRS.
  logic [PAIR_W-1:0] pc_raw, pc;
  logic [32:0]       d_in, dm_in;
  always_comb begin
    pc_raw = in_tdata[80:64];
    pc     = pc_raw;
    if (pc_raw == '0) begin
      pc = PAIR_W'(1);
    end else if (pc_raw > PAIR_W'(MAX_PAIRS)) begin
      pc = PAIR_W'(MAX_PAIRS);
    end
    d_in  = {in_tdata[63], in_tdata[63:32]} - {in_tdata[31], in_tdata[31:0]};
    dm_in = d_in[32] ? (~d_in + 33'd1) : d_in;
  end

  // Shared 32x32 multiplier.
  logic [31:0] xm, mul_a, mul_b;
  logic [63:0] mul_p, smag;
  always_comb begin
    xm   = x_r[31] ? (~x_r + 32'd1) : x_r;
    smag = s_r[63] ? (~s_r + 64'd1) : s_r;
    case (state_r)
      ST_SQ:   begin mul_a = xm;            mul_b = xm;            end
      ST_ML:   begin mul_a = prod_r[31:0];  mul_b = prod_r[31:0];  end
      ST_MM:   begin mul_a = sq_r[31:0];    mul_b = sq_r[63:32];   end
      ST_MH:   begin mul_a = sq_r[63:32];   mul_b = sq_r[63:32];   end
      ST_MUL0: begin mul_a = dm_r;          mul_b = smag[31:0];    end
      ST_MUL1: begin mul_a = dm_r;          mul_b = smag[63:32];   end
      default: begin mul_a = '0;            mul_b = '0;            end
    endcase
    mul_p = mul_a * mul_b;
  end

  // x^4 rounding and saturation from the 128-bit product in acc_r.
  logic        x4_sat;
  logic [63:0] x4;
  always_comb begin
    x4_sat = (|acc_r[127:112]) | acc_r[111];
    x4     = x4_sat ? S64_MAX : acc_r[111:48];
  end

  // Shared saturating adder.
  logic [63:0] add_a, add_b;
  logic [64:0] add_res;
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_r)
      ST_PF: begin
        add_a = x4;
        add_b = {{30{x_r[31]}}, x_r, 2'b00};
      end
      ST_ACC: begin
        add_a = i_r[0] ? k1_r : k2_r;
        add_b = f_r;
      end
      ST_COMB: begin
        case (cstep_r)
          3'd0:    begin add_a = k1_r; add_b = k1_r;              end
          3'd1:    begin add_a = t_r;  add_b = t_r;               end
          3'd2:    begin add_a = fa_r; add_b = t_r;               end
          3'd3:    begin add_a = k2_r; add_b = k2_r;              end
          3'd4:    begin add_a = s_r;  add_b = t_r;               end
          default: begin add_a = s_r;  add_b = ~fb_r + 64'd1;     end
        endcase
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
    add_res = sat_add(add_a, add_b);
  end

  // Divider step, sample step and result shaping.
  logic [DIVR_W:0]   trial;
  logic              div_ge;
  logic [N_W:0]      rsum;
  logic [33:0]       xs;
  logic [DIVR_W-1:0] div_full;
  logic              neg, q_sat;
  always_comb begin
    trial    = {rem_r, acc_r[127]};
    div_ge   = trial >= {1'b0, dvsr_r};
    rsum     = {1'b0, r_r} + {1'b0, rs_r};
    xs       = d_neg_r ? ({{2{a_r[31]}}, a_r} - {2'b00, q_r})
                       : ({{2{a_r[31]}}, a_r} + {2'b00, q_r});
    div_full = DIVR_W'({n_r, 16'd0}) + DIVR_W'({n_r, 17'd0});
    neg      = d_neg_r ^ s_r[63];
    q_sat    = (|acc_r[127:64]) || (acc_r[63:0] > S64_MIN) || (!neg && acc_r[63]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // A finishing result refills the output register itself below.
      if (out_tvalid_r && out_tready && (state_r != ST_FIN)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            a_r     <= in_tdata[31:0];
            b_r     <= in_tdata[63:32];
            n_r     <= {pc, 1'b0};
            d_neg_r <= d_in[32];
            dm_r    <= dm_in[31:0];
            q_r     <= '0;
            r_r     <= N_W'(pc);
            i_r     <= '0;
            k1_r    <= '0;
            k2_r    <= '0;
            ov_r    <= 1'b0;
            src_r   <= SRC_SAMPLE;
            acc_r   <= {96'd0, dm_in[31:0]};
            dvsr_r  <= DIVR_W'({pc, 1'b0});
            rem_r   <= '0;
            cnt_r   <= '0;
            phase_r <= 1'b0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? DIVR_W'(trial - {1'b0, dvsr_r}) : trial[DIVR_W-1:0];
          acc_r <= {acc_r[126:0], div_ge};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd127) begin
            state_r <= ST_DEND;
          end
        end
        ST_DEND: begin
          if (!phase_r) begin
            qs_r    <= acc_r[31:0];
            rs_r    <= rem_r[N_W-1:0];
            state_r <= ST_ADV;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_ADV: begin
          i_r <= i_r + N_W'(1);
          if (rsum >= {1'b0, n_r}) begin
            r_r <= N_W'(rsum - {1'b0, n_r});
            q_r <= q_r + qs_r + 32'd1;
          end else begin
            r_r <= rsum[N_W-1:0];
            q_r <= q_r + qs_r;
          end
          state_r <= ST_XS;
        end
        ST_XS: begin
          case (src_r)
            SRC_A:   x_r <= a_r;
            SRC_B:   x_r <= b_r;
            default: x_r <= xs[31:0];
          endcase
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          prod_r  <= mul_p;
          state_r <= ST_ML;
        end
        ST_ML: begin
          sq_r    <= prod_r;
          prod_r  <= mul_p;
          state_r <= ST_MM;
        end
        ST_MM: begin
          acc_r   <= {64'd0, prod_r} + (128'd1 << 47);
          prod_r  <= mul_p;
          state_r <= ST_MH;
        end
        ST_MH: begin
          acc_r   <= acc_r + {31'd0, prod_r, 33'd0};
          prod_r  <= mul_p;
          state_r <= ST_MF;
        end
        ST_MF: begin
          acc_r   <= acc_r + {prod_r, 64'd0};
          state_r <= ST_PF;
        end
        ST_PF: begin
          f_r     <= add_res[63:0];
          ov_r    <= ov_r | x4_sat | add_res[64];
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          case (src_r)
            SRC_A: begin
              fa_r    <= f_r;
              src_r   <= SRC_B;
              state_r <= ST_XS;
            end
            SRC_B: begin
              fb_r    <= f_r;
              cstep_r <= '0;
              state_r <= ST_COMB;
            end
            default: begin
              if (i_r[0]) begin
                k1_r <= add_res[63:0];
              end else begin
                k2_r <= add_res[63:0];
              end
              ov_r <= ov_r | add_res[64];
              // The even sum runs through the last point, x_n = b.
              if (i_r == n_r) begin
                src_r   <= SRC_A;
                state_r <= ST_XS;
              end else begin
                state_r <= ST_ADV;
              end
            end
          endcase
        end
        ST_COMB: begin
          ov_r    <= ov_r | add_res[64];
          cstep_r <= cstep_r + 3'd1;
          if (cstep_r == 3'd0 || cstep_r == 3'd1 || cstep_r == 3'd3) begin
            t_r <= add_res[63:0];
          end else begin
            s_r <= add_res[63:0];
          end
          if (cstep_r == 3'd5) begin
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          prod_r  <= mul_p;
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          acc_r   <= {64'd0, prod_r} + {94'd0, div_full[DIVR_W-1:1]};
          prod_r  <= mul_p;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          acc_r   <= acc_r + {32'd0, prod_r, 32'd0};
          dvsr_r  <= div_full;
          rem_r   <= '0;
          cnt_r   <= '0;
          phase_r <= 1'b1;
          state_r <= ST_DIV;
        end
        ST_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            if (q_sat) begin
              out_data_r <= neg ? S64_MIN : S64_MAX;
              out_ov_r   <= 1'b1;
            end else begin
              out_data_r <= neg ? (~acc_r[63:0] + 64'd1) : acc_r[63:0];
              out_ov_r   <= ov_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ov_r;

  // An accepted word always starts the setup division.
  `SQI_ASSERT(a_start_div, (in_tvalid && in_tready) |=> (state_r == ST_DIV), "accept did not start division")
  // The partial remainder stays below the divisor during division.
  `SQI_ASSERT(a_rem_bound, (state_r == ST_DIV) |-> (rem_r < dvsr_r), "divider remainder out of range")
  // The sample-point remainder stays below the subinterval count.
  `SQI_ASSERT(a_step_rem, (state_r == ST_ADV) |-> (r_r < n_r), "sample remainder out of range")
  // A finishing result is always placed in the output register.
  `SQI_ASSERT(a_fin_out, (state_r == ST_FIN && (!out_tvalid_r || out_tready)) |=> out_tvalid_r, "result lost")
  // The sample index never passes the subinterval count.
  `SQI_NEVER(a_idx_bound, (state_r == ST_XS) && (src_r == SRC_SAMPLE) && (i_r > n_r), "sample index overrun")

endmodule

[verif/simpson_quartic_integrator_tb.sv]
// ----------------------------------------------------------------------------
// simpson_quartic_integrator_tb
// This testbench drives bound pairs and pair counts into the integrator. Each
// returned integral and overflow flag is checked against a predictor written
// here. Both stream sides idle at random, and the receiver holds off once for
// a long stretch.
// ----------------------------------------------------------------------------
module simpson_quartic_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqi_pkg::*;

  // The slowest item runs with no handshake on either side, so the
  // quiet-cycle limit sits well above its run time.
  localparam int unsigned QUIET_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_WAIT  = 400;
  localparam int unsigned LONG_HOLD   = 2500;
  localparam int unsigned RAND_ITEMS  = 100;

  typedef struct {
    logic [63:0] integral;
    logic        overflow;
  } integral_t;

  typedef struct {
    logic [31:0] lower;
    logic [31:0] upper;
    logic [16:0] pairs;
    bit          typed;
    integral_t   want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // in_tdata, lowest bit up: lower_bound, upper_bound, pair_count, zero fill.
  logic [IN_W-1:0]    in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // out_tdata: integral.
  logic [63:0]        out_tdata;
  // out_tuser: overflow.
  logic               out_tuser;

  integral_t pending_integrals[$];
  int        errors = 0;
  bit        hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  always #4 clk = ~clk;

  simpson_quartic_integrator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Signed 64-bit add that clamps to the range and flags the clamp.
  function automatic logic signed [63:0] clamp_add(logic signed [63:0] x,
                                                   logic signed [63:0] y,
                                                   inout logic ovf);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      ovf = 1'b1;
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // f(x) = x^4 + 4x with x a Q16.16 code, result Q48.16.
  function automatic logic signed [63:0] quartic(logic signed [63:0] x, inout logic ovf);
    logic [63:0]  m;
    logic [63:0]  sq;
    logic [127:0] p;
    logic signed [63:0] x4;
    m  = magnitude(x);
    sq = m * m;
    p  = {64'd0, sq} * {64'd0, sq} + (128'd1 << 47);
    if (p[127:112] != 16'd0 || p[111]) begin
      ovf = 1'b1;
      x4  = S64_MAX;
    end else begin
      x4 = p[111:48];
    end
    return clamp_add(x4, x * 64'sd4, ovf);
  endfunction

  // Composite Simpson estimate for one word.
  function automatic integral_t simpson_estimate(logic [31:0] lower, logic [31:0] upper,
                                                 logic [16:0] pairs_in);
    logic signed [63:0] a, b, d, k1, k2, s, t, x1, x2;
    logic [63:0]  pairs, n, dm, q1, q2, dv, q;
    logic [127:0] num, quo;
    logic         ovf, neg;
    integral_t    r;
    a = {{32{lower[31]}}, lower};
    b = {{32{upper[31]}}, upper};
    pairs = pairs_in;
    if (pairs == 0) pairs = 1;
    if (pairs > MAX_PAIRS) pairs = MAX_PAIRS;
    n   = 2 * pairs;
    d   = b - a;
    dm  = magnitude(d);
    k1  = 0;
    k2  = 0;
    ovf = 1'b0;
    for (logic [63:0] i = 1; i < n; i += 2) begin
      q1 = (i * dm + n / 2) / n;
      q2 = ((i + 1) * dm + n / 2) / n;
      x1 = d[63] ? a - $signed(q1) : a + $signed(q1);
      x2 = d[63] ? a - $signed(q2) : a + $signed(q2);
      k1 = clamp_add(k1, quartic(x1, ovf), ovf);
      k2 = clamp_add(k2, quartic(x2, ovf), ovf);
    end
    t = clamp_add(k1, k1, ovf);
    t = clamp_add(t, t, ovf);
    s = clamp_add(quartic(a, ovf), t, ovf);
    t = clamp_add(k2, k2, ovf);
    s = clamp_add(s, t, ovf);
    s = clamp_add(s, -quartic(b, ovf), ovf);
    neg = d[63] != s[63];
    dv  = 3 * n * 65536;
    num = {64'd0, dm} * {64'd0, magnitude(s)} + {64'd0, dv / 2};
    quo = num / {64'd0, dv};
    if (quo[127:64] != 0 || quo[63:0] > S64_MIN || (!neg && quo[63])) begin
      ovf = 1'b1;
      r.integral = neg ? S64_MIN : S64_MAX;
    end else begin
      q = quo[63:0];
      r.integral = neg ? -q : q;
    end
    r.overflow = ovf;
    return r;
  endfunction

  // Offers one word after a random gap and waits for it to be taken. The
  // expectation is queued at the accepting edge.
  task automatic send_word(row_t row);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, row.pairs, row.upper, row.lower};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (row.typed) pending_integrals.push_back(row.want);
    else pending_integrals.push_back(simpson_estimate(row.lower, row.upper, row.pairs));
  endtask

  // Receiver: random gap per word, one long hold on request.
  initial begin
    int unsigned gap;
    integral_t   want;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap > 0 || hold_request) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        if (hold_request) begin
          repeat (LONG_HOLD) @(posedge clk);
          hold_request = 1'b0;
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (pending_integrals.size() == 0) begin
        $error("unexpected result word: integral %h overflow %b", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_integrals.pop_front();
        if (out_tdata !== want.integral) begin
          $error("integral: expected %h actual %h", want.integral, out_tdata);
          errors++;
        end
        if (out_tuser !== want.overflow) begin
          $error("overflow: expected %b actual %b", want.overflow, out_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL simpson_quartic_integrator");
        $finish;
      end
    end
  end

  function automatic logic [31:0] random_bound();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 524288) - 262144;  // within +-4.0
      2: return $urandom_range(0, 16777216) - 8388608;
      default: return $urandom_range(0, 65536) + 32'h7FFF_0000;
    endcase
  endfunction

  initial begin
    row_t directed[$];
    row_t row;
    // Equal bounds give zero; at the most negative code f itself saturates.
    directed.push_back('{32'h0, 32'h0, 17'd1, 1'b1, '{64'd0, 1'b0}});
    directed.push_back('{32'h8000_0000, 32'h8000_0000, 17'd1, 1'b1, '{64'd0, 1'b1}});
    directed.push_back('{32'h0, 32'h0001_0000, 17'd1, 1'b0, '{64'd0, 1'b0}});
    directed.push_back('{32'h0001_0000, 32'h0, 17'd1, 1'b0, '{64'd0, 1'b0}});
    directed.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 17'd1, 1'b0, '{64'd0, 1'b0}});
    directed.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 17'd2, 1'b0, '{64'd0, 1'b0}});
    directed.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd3, 1'b0, '{64'd0, 1'b0}});
    // Zero pair count acts as one pair.
    directed.push_back('{32'h0, 32'h0002_0000, 17'd0, 1'b0, '{64'd0, 1'b0}});
    directed.push_back('{32'hFFFF_0000, 32'h0001_0000, 17'd4, 1'b0, '{64'd0, 1'b0}});
    directed.push_back('{32'h1234_5678, 32'hEDCB_A987, 17'd7, 1'b0, '{64'd0, 1'b0}});
    directed.push_back('{32'hFFFE_0000, 32'h0003_8000, 17'd16, 1'b0, '{64'd0, 1'b0}});
    // Pair count above the maximum is clamped; this is the one long item.
    directed.push_back('{32'h0, 32'h0002_0000, 17'h1FFFF, 1'b0, '{64'd0, 1'b0}});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_word(directed[k]);

    // The receiver stops for a long stretch while words keep coming.
    hold_request = 1'b1;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      row.lower = random_bound();
      row.upper = ($urandom_range(0, 9) == 0) ? row.lower : random_bound();
      row.pairs = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(9, 64))
                                              : 17'($urandom_range(0, 8));
      row.typed = 1'b0;
      row.want  = '{64'd0, 1'b0};
      send_word(row);
    end
    in_tvalid <= 1'b0;

    while (pending_integrals.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_integrals.size() == 0) begin
      $display("PASS simpson_quartic_integrator");
    end else begin
      $display("FAIL simpson_quartic_integrator");
    end
    $finish;
  end

endmodule
